[hw/rtl/hsvrpc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the HSV red pixel classifier.
// No dependencies; imported by hsvrpc_divider and hsv_red_pixel_classifier.

package hsvrpc_pkg;

    // Channel and arithmetic widths
    localparam int CH_W       = 8;
    localparam int NUM_W      = 16;
    localparam int T_W        = 18;
    localparam int DIFF_W     = CH_W + 1;
    localparam int CFG_IDX_W  = 4;

    // Pipeline layout: max/min, hue term, numerators, divider, output
    localparam int DIV_STAGES = CH_W;
    localparam int S_MAXMIN   = 0;
    localparam int S_HUE      = 1;
    localparam int S_NUM      = 2;
    localparam int S_DIV0     = 3;
    localparam int S_OUT      = S_DIV0 + DIV_STAGES;
    localparam int NSTG       = S_OUT + 1;

    // Largest hue in half degrees
    localparam logic [CH_W-1:0] HUE_MAX = 8'd180;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_LOW_A  = 4'd0,
        REG_HUE_HIGH_A = 4'd1,
        REG_HUE_LOW_B  = 4'd2,
        REG_HUE_HIGH_B = 4'd3,
        REG_SAT_LOW    = 4'd4,
        REG_SAT_HIGH   = 4'd5,
        REG_VAL_LOW    = 4'd6,
        REG_VAL_HIGH   = 4'd7
    } cfg_idx_t;

    // Register reset values
    localparam logic [CH_W-1:0] RST_HUE_LOW_A  = 8'd0;
    localparam logic [CH_W-1:0] RST_HUE_HIGH_A = 8'd10;
    localparam logic [CH_W-1:0] RST_HUE_LOW_B  = 8'd170;
    localparam logic [CH_W-1:0] RST_HUE_HIGH_B = 8'd180;
    localparam logic [CH_W-1:0] RST_SAT_LOW    = 8'd120;
    localparam logic [CH_W-1:0] RST_SAT_HIGH   = 8'd255;
    localparam logic [CH_W-1:0] RST_VAL_LOW    = 8'd70;
    localparam logic [CH_W-1:0] RST_VAL_HIGH   = 8'd255;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } max_sel_t;

endpackage

[hw/rtl/hsvrpc_divider.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, 8-bit quotient.
// Depends on hsvrpc_pkg; stage loads are driven by the parent's flow control.

module hsvrpc_divider
    import hsvrpc_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] load,
    input  logic [NUM_W-1:0]      num,
    input  logic [CH_W-1:0]       den,
    output logic [CH_W-1:0]       quo
);

    logic [NUM_W-1:0] rem_reg [DIV_STAGES-1];
    logic [CH_W-1:0]  den_reg [DIV_STAGES-1];
    logic [CH_W-1:0]  quo_reg [DIV_STAGES];

    logic [NUM_W-1:0] rem_in   [DIV_STAGES];
    logic [CH_W-1:0]  den_in   [DIV_STAGES];
    logic [CH_W-1:0]  quo_in   [DIV_STAGES];
    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [CH_W-1:0]  quo_next [DIV_STAGES];
    logic [NUM_W-1:0] trial    [DIV_STAGES];

    // Feed the first stage from the ports
    assign rem_in[0] = num;
    assign den_in[0] = den;
    assign quo_in[0] = '0;

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++) begin : g_stage
            // Chain each stage to the previous register
            if (j > 0) begin : g_link
                assign rem_in[j] = rem_reg[j-1];
                assign den_in[j] = den_reg[j-1];
                assign quo_in[j] = quo_reg[j-1];
            end

            // Try the shifted divisor; keep the bit if it fits
            assign trial[j] = NUM_W'(den_in[j]) << (DIV_STAGES - 1 - j);

            always_comb
            begin
                if (rem_in[j] >= trial[j])
                begin
                    rem_next[j] = rem_in[j] - trial[j];
                    quo_next[j] = quo_in[j] | (CH_W'(1) << (DIV_STAGES - 1 - j));
                end
                else
                begin
                    rem_next[j] = rem_in[j];
                    quo_next[j] = quo_in[j];
                end
            end

            // Hold the quotient in every stage
            always_ff @(posedge clk)
            begin
                if (load[j])
                begin
                    quo_reg[j] <= quo_next[j];
                end
            end

            // Remainder and divisor are needed only by later stages
            if (j < DIV_STAGES - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (load[j])
                    begin
                        rem_reg[j] <= rem_next[j];
                        den_reg[j] <= den_in[j];
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

[hw/rtl/hsv_red_pixel_classifier.sv]
`timescale 1ns / 1ps
// Top level: BGR pixel to HSV, then window test for red; config registers.
// Depends on hsvrpc_pkg and hsvrpc_divider (two instances: saturation, hue).
//
//  Channel | Handshake           | Payload
//  --------+---------------------+----------------------------------
//  in      | in_valid, in_ready  | blue, green, red (8 bits each)
//  out     | out_valid, out_ready| is_red (1 bit)
//  cfg     | cfg_valid, cfg_ready| cfg_index (4 bits), cfg_data (8)
//
// One pixel per cycle sustained while out_ready is high; the pipeline from input
// transfer to result is the 8-stage divider plus three front stages and the
// output register. Each stage holds only while it is full and the next one is
// held, so bubbles close up during an output stall. Reset empties the pipeline
// and loads the default red windows; cfg_ready is always high.

module hsv_red_pixel_classifier
    import hsvrpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CH_W-1:0]      blue,
    input  logic [CH_W-1:0]      green,
    input  logic [CH_W-1:0]      red,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 is_red,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CH_W-1:0]      cfg_data
);

    // Configuration registers
    logic [CH_W-1:0] hue_low_a_reg, hue_high_a_reg, hue_low_b_reg, hue_high_b_reg;
    logic [CH_W-1:0] sat_low_reg, sat_high_reg, val_low_reg, val_high_reg;

    // Flow control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] src_vld;
    logic [NSTG-1:0] ld;

    // Stage 0: max, min, difference
    logic [CH_W-1:0]          mx_c, mn_c;
    logic signed [DIFF_W-1:0] diff_c;
    max_sel_t                 sel_c;
    logic [CH_W-1:0]          mx0_reg, d0_reg;
    logic signed [DIFF_W-1:0] diff0_reg;
    max_sel_t                 sel0_reg;

    // Stage 1: hue term in degrees times d, saturation numerator
    logic [NUM_W-1:0]      off_c;
    logic signed [T_W-1:0] t_c;
    logic [NUM_W-1:0]      satn_c;
    logic [CH_W-1:0]       mx1_reg, d1_reg;
    logic signed [T_W-1:0] t1_reg;
    logic [NUM_W-1:0]      satn1_reg;

    // Stage 2: wrapped hue numerator, divisors
    logic [T_W-2:0]        d360_c;
    logic signed [T_W-1:0] wrap_c;
    logic [T_W-1:0]        hsum_c;
    logic [CH_W-1:0]       mx2_reg;
    logic [NUM_W-1:0]      satn2_reg, huen2_reg;
    logic [CH_W-1:0]       satd2_reg, hued2_reg;

    // Divider stages and output
    logic [CH_W-1:0] val_pipe_reg [DIV_STAGES];
    logic [CH_W-1:0] sat_q, hue_q;
    logic            hit_c;
    logic            is_red_reg;

    assign cfg_ready = 1'b1;

    // Write a configuration register; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_a_reg  <= RST_HUE_LOW_A;
            hue_high_a_reg <= RST_HUE_HIGH_A;
            hue_low_b_reg  <= RST_HUE_LOW_B;
            hue_high_b_reg <= RST_HUE_HIGH_B;
            sat_low_reg    <= RST_SAT_LOW;
            sat_high_reg   <= RST_SAT_HIGH;
            val_low_reg    <= RST_VAL_LOW;
            val_high_reg   <= RST_VAL_HIGH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_HUE_LOW_A:  hue_low_a_reg  <= cfg_data;
                REG_HUE_HIGH_A: hue_high_a_reg <= cfg_data;
                REG_HUE_LOW_B:  hue_low_b_reg  <= cfg_data;
                REG_HUE_HIGH_B: hue_high_b_reg <= cfg_data;
                REG_SAT_LOW:    sat_low_reg    <= cfg_data;
                REG_SAT_HIGH:   sat_high_reg   <= cfg_data;
                REG_VAL_LOW:    val_low_reg    <= cfg_data;
                REG_VAL_HIGH:   val_high_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it or any later stage is empty, or output is taken
    always_comb
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            src_vld[i] = (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
        end
        for (int i = 0; i < NSTG; i++)
        begin
            rdy[i]      = out_ready || !(&(vld_reg | ((NSTG'(1) << i) - NSTG'(1))));
            ld[i]       = rdy[i] && src_vld[i];
            vld_next[i] = rdy[i] ? src_vld[i] : vld_reg[i];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready = rdy[S_MAXMIN];

    // Find max, min and the channel that owns the max (red, green, blue order)
    always_comb
    begin
        mx_c = red;
        if (green > mx_c) mx_c = green;
        if (blue > mx_c)  mx_c = blue;
        mn_c = red;
        if (green < mn_c) mn_c = green;
        if (blue < mn_c)  mn_c = blue;
        priority if (mx_c == red)
        begin
            sel_c  = MAX_RED;
            diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (mx_c == green)
        begin
            sel_c  = MAX_GREEN;
            diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sel_c  = MAX_BLUE;
            diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_MAXMIN])
        begin
            mx0_reg   <= mx_c;
            d0_reg    <= mx_c - mn_c;
            diff0_reg <= diff_c;
            sel0_reg  <= sel_c;
        end
    end

    // Form 60*diff + offset*d and 255*d + max/2
    always_comb
    begin
        unique case (sel0_reg)
            MAX_RED:   off_c = '0;
            MAX_GREEN: off_c = NUM_W'(d0_reg) * NUM_W'(120);
            MAX_BLUE:  off_c = NUM_W'(d0_reg) * NUM_W'(240);
            default:   off_c = '0;
        endcase
        t_c = $signed({{(T_W - DIFF_W){diff0_reg[DIFF_W-1]}}, diff0_reg}) * $signed(T_W'(60))
            + $signed({{(T_W - NUM_W){1'b0}}, off_c});
        satn_c = ({d0_reg, {CH_W{1'b0}}} - NUM_W'(d0_reg)) + NUM_W'(mx0_reg[CH_W-1:1]);
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_HUE])
        begin
            mx1_reg   <= mx0_reg;
            d1_reg    <= d0_reg;
            t1_reg    <= t_c;
            satn1_reg <= satn_c;
        end
    end

    // Wrap negative hue, add half a step for rounding, guard zero divisors
    always_comb
    begin
        d360_c = (T_W-1)'(d1_reg) * (T_W-1)'(360);
        wrap_c = t1_reg[T_W-1] ? t1_reg + $signed({1'b0, d360_c}) : t1_reg;
        hsum_c = $unsigned(wrap_c) + T_W'(d1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_NUM])
        begin
            mx2_reg   <= mx1_reg;
            satn2_reg <= satn1_reg;
            satd2_reg <= (mx1_reg == '0) ? CH_W'(1) : mx1_reg;
            huen2_reg <= hsum_c[NUM_W:1];
            hued2_reg <= (d1_reg == '0) ? CH_W'(1) : d1_reg;
        end
    end

    // Divide both numerators, one quotient bit per stage
    hsvrpc_divider u_sat_div (
        .clk  (clk),
        .load (ld[S_OUT-1:S_DIV0]),
        .num  (satn2_reg),
        .den  (satd2_reg),
        .quo  (sat_q)
    );

    hsvrpc_divider u_hue_div (
        .clk  (clk),
        .load (ld[S_OUT-1:S_DIV0]),
        .num  (huen2_reg),
        .den  (hued2_reg),
        .quo  (hue_q)
    );

    // Carry value alongside the divider
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (ld[S_DIV0 + j])
            begin
                val_pipe_reg[j] <= (j == 0) ? mx2_reg : val_pipe_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // Test the windows
    always_comb
    begin
        hit_c = (sat_q >= sat_low_reg) && (sat_q <= sat_high_reg)
             && (val_pipe_reg[DIV_STAGES-1] >= val_low_reg)
             && (val_pipe_reg[DIV_STAGES-1] <= val_high_reg)
             && (((hue_q >= hue_low_a_reg) && (hue_q <= hue_high_a_reg))
              || ((hue_q >= hue_low_b_reg) && (hue_q <= hue_high_b_reg)));
    end

    always_ff @(posedge clk)
    begin
        if (ld[S_OUT])
        begin
            is_red_reg <= hit_c;
        end
    end

    assign out_valid = vld_reg[S_OUT];
    assign is_red    = is_red_reg;

    // An accepted output always frees room for an input
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output is taken");

    // A full stage over an empty one moves forward
    a_no_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[S_MAXMIN] && !vld_reg[S_HUE]) |=> vld_reg[S_HUE])
        else $error("stage held over an empty successor");

    // Divisors are never zero and quotients fit eight bits
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_NUM] |-> (satd2_reg != '0) && (hued2_reg != '0)
            && (satn2_reg < {satd2_reg, {CH_W{1'b0}}})
            && (huen2_reg < {hued2_reg, {CH_W{1'b0}}}))
        else $error("divider operands out of range");

    // Hue stays within a full turn (180 half degrees)
    a_hue_max: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_OUT-1] |-> (hue_q <= HUE_MAX))
        else $error("hue above 180");

endmodule
